// ----- src/mlpf_pkg.sv -----
`timescale 1ns / 1ps

package mlpf_pkg;

   localparam int DataWidth = 16;
   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth = 48;
   localparam int TableDepth = 256;
   localparam int IndexWidth = 8;

   typedef logic signed [DataWidth-1:0] sample_type;
   typedef logic [DataWidth-1:0] act_type;
   typedef logic [IndexWidth-1:0] index_type;
   typedef logic [TableDepth-1:0][DataWidth-1:0] sig_table_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_HIDDEN0 = 8'd0,
      CSR_HIDDEN1 = 8'd1,
      CSR_HIDDEN2 = 8'd2,
      CSR_OUTPUT  = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic mul;
      logic index;
      logic lookup;
   } hid_en_type;

   localparam logic [63:0] QONE   = 64'h0100_0000_0000_0000;
   localparam logic [63:0] BIAS40 = 64'h0000_0100_0000_0000;
   localparam logic [63:0] MASK28 = 64'h0000_0000_0FFF_FFFF;

   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int i;
      rem = '0;
      quo = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [63:0] a1;
      logic [63:0] a0;
      logic [63:0] b1;
      logic [63:0] b0;
      a1 = a >> 28;
      a0 = a & MASK28;
      b1 = b >> 28;
      b0 = b & MASK28;
      return a1 * b1 + ((a1 * b0 + a0 * b1) >> 28) + ((a0 * b0) >> 56);
   endfunction

   // Sigmoid table built with exact integer arithmetic during elaboration.
   function automatic sig_table_type sig_build();
      sig_table_type tbl;
      logic [63:0] term;
      logic [63:0] r;
      logic [63:0] p;
      logic [63:0] p40;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] quo;
      int n;
      int m;
      tbl = '0;
      term = QONE;
      r = QONE;
      p = QONE;
      for (n = 1; n <= 14; n++) begin
         term = udiv64(term, 64'(16 * n));
         if ((n % 2) == 1) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      for (m = 0; m <= 128; m++) begin
         p40 = p >> 16;
         den = BIAS40 + p40;
         if (m <= 127) begin
            num = 64'd65535 * BIAS40;
            quo = udiv64(2 * num + den, 2 * den);
            tbl[128 + m] = quo[DataWidth-1:0];
         end
         if (m >= 1) begin
            num = 64'd65535 * p40;
            quo = udiv64(2 * num + den, 2 * den);
            tbl[128 - m] = quo[DataWidth-1:0];
         end
         p = qmul(p, r);
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = sig_build();

   // Hidden sum is Q9.24; floor to Q4.12, saturate, and form the table index.
   function automatic index_type hid_index(logic signed [32:0] s);
      logic signed [20:0] q;
      q = 21'(s >>> 12);
      if (!q[20] && (q[19:15] != 5'b00000)) begin
         return '1;
      end else if (q[20] && (q[19:15] != 5'b11111)) begin
         return '0;
      end else begin
         return {~q[15], q[14:8]};
      end
   endfunction

   // Output sum is Q7.28; floor to Q4.12, saturate, and form the table index.
   function automatic index_type out_index(logic signed [34:0] s);
      logic signed [18:0] q;
      q = 19'(s >>> 16);
      if (!q[18] && (q[17:15] != 3'b000)) begin
         return '1;
      end else if (q[18] && (q[17:15] != 3'b111)) begin
         return '0;
      end else begin
         return {~q[15], q[14:8]};
      end
   endfunction

endpackage

// ----- src/mlpf_req_if.sv -----
`timescale 1ns / 1ps

interface mlpf_req_if;
   logic valid;
   logic ready;
   mlpf_pkg::sample_type x_first;
   mlpf_pkg::sample_type x_second;

   modport source (output valid, output x_first, output x_second, input ready);
   modport sink (input valid, input x_first, input x_second, output ready);
endinterface

// ----- src/mlpf_rsp_if.sv -----
`timescale 1ns / 1ps

interface mlpf_rsp_if;
   logic valid;
   logic ready;
   mlpf_pkg::act_type activation;

   modport source (output valid, output activation, input ready);
   modport sink (input valid, input activation, output ready);
endinterface

// ----- src/mlp_forward_2_3_1.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Contents
// req_ch    in         x_first, x_second (signed Q4.12)
// rsp_ch    out        activation (unsigned Q0.16)
// csr_*     in         write enable, register index, 48-bit write data
//
// Each accepted transaction passes through the register stages below, and one
// transaction is accepted every cycle when the output side keeps up.
// The six register stages are: hidden products, hidden index, hidden table,
// output products, output index, output table.
// Reset clears the weight registers and the stage valid bits.
// A stall holds only the stages that are full, so bubbles still close up.

module mlp_forward_2_3_1 (
   input  logic                                      clock,
   input  logic                                      reset,
   mlpf_req_if.sink                                  req_ch,
   mlpf_rsp_if.source                                rsp_ch,
   input  logic                                      csr_write_enable,
   input  logic [mlpf_pkg::CsrIndexWidth-1:0]        csr_index,
   input  logic [mlpf_pkg::CsrDataWidth-1:0]         csr_write_data
);

   logic [31:0] hid_weights_ff [3];
   logic [47:0] out_weights_ff;

   logic [5:0] valid_ff;
   logic [5:0] valid_in;
   logic [5:0] en;

   mlpf_pkg::hid_en_type hid_en;
   mlpf_pkg::act_type hidden [3];

   logic signed [32:0] oprod_ff [3];
   logic signed [32:0] oprod_in [3];
   mlpf_pkg::index_type oindex_ff;
   mlpf_pkg::index_type oindex_in;
   mlpf_pkg::act_type act_ff;
   mlpf_pkg::act_type act_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hid_weights_ff[0] <= '0;
         hid_weights_ff[1] <= '0;
         hid_weights_ff[2] <= '0;
         out_weights_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            mlpf_pkg::CSR_HIDDEN0: hid_weights_ff[0] <= csr_write_data[31:0];
            mlpf_pkg::CSR_HIDDEN1: hid_weights_ff[1] <= csr_write_data[31:0];
            mlpf_pkg::CSR_HIDDEN2: hid_weights_ff[2] <= csr_write_data[31:0];
            mlpf_pkg::CSR_OUTPUT:  out_weights_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A stage loads when it is empty or its contents move on in this cycle.
   always_comb begin
      en[5] = !valid_ff[5] || rsp_ch.ready;
      for (int i = 4; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = req_ch.valid;
      for (int i = 1; i < 6; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < 6; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign hid_en = '{mul: en[0], index: en[1], lookup: en[2]};

   for (genvar g = 0; g < 3; g++) begin : g_hidden
      mlpf_hidden u_hidden (
         .clock    (clock),
         .en       (hid_en),
         .x_first  (req_ch.x_first),
         .x_second (req_ch.x_second),
         .weights  (hid_weights_ff[g]),
         .hidden   (hidden[g])
      );
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         oprod_in[j] = $signed({1'b0, hidden[j]}) * $signed(out_weights_ff[16*j +: 16]);
      end
      oindex_in = mlpf_pkg::out_index(35'(oprod_ff[0]) + 35'(oprod_ff[1])
                                      + 35'(oprod_ff[2]));
      act_in = mlpf_pkg::SIG_TABLE[oindex_ff];
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         oprod_ff <= oprod_in;
      end
      if (en[4]) begin
         oindex_ff <= oindex_in;
      end
      if (en[5]) begin
         act_ff <= act_in;
      end
   end

   assign req_ch.ready = en[0];
   assign rsp_ch.valid = valid_ff[5];
   assign rsp_ch.activation = act_ff;

endmodule

// ----- src/mlpf_hidden.sv -----
`timescale 1ns / 1ps

module mlpf_hidden (
   input  logic                 clock,
   input  mlpf_pkg::hid_en_type en,
   input  mlpf_pkg::sample_type x_first,
   input  mlpf_pkg::sample_type x_second,
   input  logic [31:0]          weights,
   output mlpf_pkg::act_type    hidden
);

   logic signed [31:0] prod0_ff;
   logic signed [31:0] prod1_ff;
   logic signed [31:0] prod0_in;
   logic signed [31:0] prod1_in;
   mlpf_pkg::index_type index_ff;
   mlpf_pkg::index_type index_in;
   mlpf_pkg::act_type hidden_ff;
   mlpf_pkg::act_type hidden_in;

   always_comb begin
      prod0_in = x_first * $signed(weights[15:0]);
      prod1_in = x_second * $signed(weights[31:16]);
      index_in = mlpf_pkg::hid_index(33'(prod0_ff) + 33'(prod1_ff));
      hidden_in = mlpf_pkg::SIG_TABLE[index_ff];
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
      end
      if (en.index) begin
         index_ff <= index_in;
      end
      if (en.lookup) begin
         hidden_ff <= hidden_in;
      end
   end

   assign hidden = hidden_ff;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CycleLimit = 1_000_000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned ReportLimit = 10;
   localparam int unsigned RandomRounds = 8;
   localparam int unsigned RoundSamples = 216;
   localparam logic [mlpf_pkg::CsrIndexWidth-1:0] SpareCsrIndex = 8'd4;
   localparam logic [mlpf_pkg::CsrIndexWidth-1:0] TopCsrIndex = 8'hFF;
   localparam longint unsigned OneQ56 = 64'h0100_0000_0000_0000;
   localparam longint unsigned Bias40 = 64'h0000_0100_0000_0000;
   localparam longint unsigned Mask28 = 64'h0000_0000_0FFF_FFFF;

   typedef struct {
      mlpf_pkg::sample_type x_first;
      mlpf_pkg::sample_type x_second;
      int unsigned gap_after;
   } sample_item_type;

   typedef struct {
      mlpf_pkg::sample_type x_first;
      mlpf_pkg::sample_type x_second;
      mlpf_pkg::act_type activation;
   } activation_entry_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [mlpf_pkg::CsrIndexWidth-1:0] csr_index;
   logic [mlpf_pkg::CsrDataWidth-1:0] csr_write_data;

   mlpf_req_if req_bus ();
   mlpf_rsp_if rsp_bus ();

   mlpf_pkg::act_type sigmoid_lut [mlpf_pkg::TableDepth];
   logic [31:0] hidden_weights [3];
   logic [47:0] output_weights;

   sample_item_type sample_backlog [$];
   activation_entry_type predicted_activations [$];

   bit req_fire;
   bit req_calm;
   bit rsp_calm;
   int unsigned idle_left;
   int unsigned stall_left;
   int unsigned cycle_count;
   int unsigned samples_queued;
   int unsigned results_checked;
   int unsigned mismatch_count;
   int unsigned weight_settings;

   mlp_forward_2_3_1 i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The sigmoid table is rebuilt with exact integer arithmetic: a Taylor series gives
   // exp(-1/16) in Q0.56, and its powers give both halves of the table.
   initial begin : build_sigmoid
      longint unsigned term;
      longint unsigned ratio;
      longint unsigned power;
      longint unsigned power40;
      longint unsigned denom;
      longint unsigned hi_p;
      longint unsigned lo_p;
      longint unsigned hi_r;
      longint unsigned lo_r;
      term = OneQ56;
      ratio = OneQ56;
      power = OneQ56;
      for (int n = 1; n <= 14; n++) begin
         term = term / longint'(16 * n);
         if (n % 2 == 1) begin
            ratio = ratio - term;
         end else begin
            ratio = ratio + term;
         end
      end
      for (int m = 0; m <= 128; m++) begin
         power40 = power >> 16;
         denom = Bias40 + power40;
         if (m <= 127) begin
            sigmoid_lut[128 + m] =
               mlpf_pkg::act_type'((2 * 65535 * Bias40 + denom) / (2 * denom));
         end
         if (m >= 1) begin
            sigmoid_lut[128 - m] =
               mlpf_pkg::act_type'((2 * 65535 * power40 + denom) / (2 * denom));
         end
         hi_p = power >> 28;
         lo_p = power & Mask28;
         hi_r = ratio >> 28;
         lo_r = ratio & Mask28;
         power = hi_p * hi_r + ((hi_p * lo_r + lo_p * hi_r) >> 28) + ((lo_p * lo_r) >> 56);
      end
   end

   function automatic mlpf_pkg::act_type sigmoid_of(longint acc, int unsigned frac_bits);
      longint level;
      level = acc >>> frac_bits;
      if (level > 32767) begin
         level = 32767;
      end else if (level < -32768) begin
         level = -32768;
      end
      return sigmoid_lut[int'((level + 32768) >>> 8)];
   endfunction

   function automatic mlpf_pkg::act_type predict_activation(mlpf_pkg::sample_type x_first,
                                                            mlpf_pkg::sample_type x_second);
      mlpf_pkg::act_type hidden [3];
      longint acc;
      for (int j = 0; j < 3; j++) begin
         acc = longint'(x_first) * longint'($signed(hidden_weights[j][15:0]))
             + longint'(x_second) * longint'($signed(hidden_weights[j][31:16]));
         hidden[j] = sigmoid_of(acc, 12);
      end
      acc = 0;
      for (int j = 0; j < 3; j++) begin
         acc += longint'(hidden[j]) * longint'($signed(output_weights[16*j +: 16]));
      end
      return sigmoid_of(acc, 16);
   endfunction

   function automatic int unsigned draw_gap(bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 65) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] draw_word(int unsigned span);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 16'($urandom_range(0, 2 * span) - span);
      end
      if (roll < 85) begin
         return 16'($urandom);
      end
      case ($urandom_range(0, 4))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0001;
         3: return 16'hFFFF;
         default: return 16'h0000;
      endcase
   endfunction

   task automatic queue_sample(logic [15:0] first, logic [15:0] second);
      sample_backlog.push_back('{x_first: first, x_second: second,
                                 gap_after: draw_gap(req_calm)});
      samples_queued++;
   endtask

   task automatic write_csr(logic [mlpf_pkg::CsrIndexWidth-1:0] reg_index,
                            logic [mlpf_pkg::CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= reg_index;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   task automatic load_weights(logic [31:0] h0, logic [31:0] h1, logic [31:0] h2,
                               logic [47:0] out_w);
      write_csr(mlpf_pkg::CSR_HIDDEN0, {16'($urandom), h0});
      write_csr(mlpf_pkg::CSR_HIDDEN1, {16'($urandom), h1});
      write_csr(mlpf_pkg::CSR_HIDDEN2, {16'($urandom), h2});
      write_csr(mlpf_pkg::CSR_OUTPUT, out_w);
      write_csr((weight_settings % 2) ? SpareCsrIndex : TopCsrIndex,
                {16'($urandom), 16'($urandom), 16'($urandom)});
      csr_write_enable <= 1'b0;
      weight_settings++;
   endtask

   task automatic wait_idle();
      while (results_checked < samples_queued) begin
         @(negedge clock);
      end
      repeat (DrainCycles) @(negedge clock);
   endtask

   always @(negedge clock) begin : drive_samples
      sample_item_type next_sample;
      if (reset) begin
         req_bus.valid <= 1'b0;
         idle_left = 0;
      end else if (!req_bus.valid || req_fire) begin
         if (idle_left > 0) begin
            idle_left--;
            req_bus.valid <= 1'b0;
         end else if (sample_backlog.size() > 0) begin
            next_sample = sample_backlog.pop_front();
            req_bus.x_first <= next_sample.x_first;
            req_bus.x_second <= next_sample.x_second;
            req_bus.valid <= 1'b1;
            idle_left = next_sample.gap_after;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if ($urandom_range(0, 299) == 0) begin
         rsp_calm = !rsp_calm;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = draw_gap(rsp_calm);
      end
   end

   always @(posedge clock) begin : check_results
      activation_entry_type oldest;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Run stopped after %0d cycles with %0d of %0d activations checked",
                  CycleLimit, results_checked, samples_queued);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (reset) begin
         req_fire = 1'b0;
         hidden_weights = '{default: '0};
         output_weights = '0;
      end else begin
         req_fire = req_bus.valid && req_bus.ready;
         if (csr_write_enable) begin
            case (csr_index)
               mlpf_pkg::CSR_HIDDEN0: hidden_weights[0] = csr_write_data[31:0];
               mlpf_pkg::CSR_HIDDEN1: hidden_weights[1] = csr_write_data[31:0];
               mlpf_pkg::CSR_HIDDEN2: hidden_weights[2] = csr_write_data[31:0];
               mlpf_pkg::CSR_OUTPUT: output_weights = csr_write_data[47:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            predicted_activations.push_back('{req_bus.x_first, req_bus.x_second,
               predict_activation(req_bus.x_first, req_bus.x_second)});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_activations.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("Activation %h arrived with no transaction outstanding",
                           rsp_bus.activation);
               end
            end else begin
               oldest = predicted_activations.pop_front();
               results_checked++;
               if (rsp_bus.activation !== oldest.activation) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportLimit) begin
                     $display("Activation for x_first=%0d x_second=%0d: expected %h, got %h",
                              oldest.x_first, oldest.x_second, oldest.activation,
                              rsp_bus.activation);
                  end
               end
            end
         end
      end
   end

   initial begin : run_stimulus
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.x_first = '0;
      req_bus.x_second = '0;
      rsp_bus.ready = 1'b0;
      req_calm = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Weights are all zero straight after reset.
      @(posedge clock);
      queue_sample(16'h0000, 16'h0000);
      queue_sample(16'h7FFF, 16'h8000);
      queue_sample(16'h8000, 16'h7FFF);
      wait_idle();

      load_weights({16'h1000, 16'h1000}, {16'hF000, 16'h1000}, {16'h7FFF, 16'h8000},
                   {16'h7FFF, 16'hF000, 16'h1000});
      @(posedge clock);
      queue_sample(16'h0000, 16'h0000);
      queue_sample(16'h7FFF, 16'h7FFF);
      queue_sample(16'h8000, 16'h8000);
      queue_sample(16'h7FFF, 16'h8000);
      queue_sample(16'h0100, 16'hFF00);
      queue_sample(16'h0001, 16'hFFFF);
      queue_sample(16'hFFFF, 16'h0000);
      queue_sample(16'h00FF, 16'h0000);
      queue_sample(16'h0800, 16'h0000);
      wait_idle();

      load_weights(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 48'h8000_8000_8000);
      @(posedge clock);
      queue_sample(16'h7FFF, 16'h7FFF);
      queue_sample(16'h8000, 16'h8000);
      queue_sample(16'h0001, 16'h0001);
      queue_sample(16'hFFFF, 16'hFFFF);
      wait_idle();

      load_weights(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
      @(posedge clock);
      queue_sample(16'h0010, 16'hFFF0);
      queue_sample(16'h0000, 16'h0001);
      queue_sample(16'h7FFF, 16'h0000);
      queue_sample(16'h8000, 16'h0000);
      wait_idle();

      // A unit weight passes x_first straight into the first hidden unit, so these land on table index edges.
      load_weights({16'h0000, 16'h1000}, {16'h1000, 16'h0000}, {16'hF000, 16'hF000},
                   {16'h1000, 16'h0000, 16'h0000});
      @(posedge clock);
      queue_sample(16'h00FF, 16'h0000);
      queue_sample(16'h0100, 16'h0000);
      queue_sample(16'hFF00, 16'h0000);
      queue_sample(16'hFEFF, 16'h0000);

      for (int round = 0; round < RandomRounds; round++) begin
         wait_idle();
         load_weights({draw_word(16'h1000), draw_word(16'h1000)},
                      {draw_word(16'h1000), draw_word(16'h1000)},
                      {draw_word(16'h1000), draw_word(16'h1000)},
                      {draw_word(16'h1000), draw_word(16'h1000), draw_word(16'h1000)});
         req_calm = (round % 3 == 2);
         @(posedge clock);
         repeat (RoundSamples) queue_sample(draw_word(16'h2000), draw_word(16'h2000));
      end
      wait_idle();

      if (predicted_activations.size() != 0) begin
         mismatch_count++;
         $display("%0d predicted activations never arrived", predicted_activations.size());
      end
      $display("Summary: %0d samples under %0d weight settings, %0d activations checked.",
               samples_queued, weight_settings, results_checked);
      $display("Summary: each weight setting also wrote an unused register index; %0d %s",
               mismatch_count, "mismatches were found.");
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
